### sv/tcaoq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaoq_pkg
// Shared sizes, codes and types of the two-class age-ordered queue.
// ----------------------------------------------------------------------------
package tcaoq_pkg;

  // Sizes of the queues and the item fields.
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int STAMP_BITS  = 8;

  // Derived widths.
  localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_BITS = ((TAG_BITS + 7) / 8) * 8;

  // Operation selector carried with each request.
  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ_ANY = 2'd1,
    OP_DEQ_C0  = 2'd2,
    OP_DEQ_C1  = 2'd3
  } op_t;

  // Status returned with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // One queue entry: payload tag and arrival stamp.
  typedef struct packed {
    tag_t   tag;
    stamp_t stamp;
  } entry_t;

  // Occupancy report of one class queue.
  typedef struct packed {
    logic                empty;
    logic                full;
    logic [CNT_BITS-1:0] count;
  } fifo_stat_t;

  // One result item.
  typedef struct packed {
    tag_t    tag;
    logic    kind;
    status_t status;
  } result_t;

endpackage

### sv/tcaoq_class_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaoq_class_fifo
// Bounded circular queue for one item class with its head entry always
// visible, so a pop decision can be made in the same cycle as a request.
// ----------------------------------------------------------------------------
module tcaoq_class_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tcaoq_pkg::entry_t     push_entry,
  input  logic                  pop,
  output tcaoq_pkg::entry_t     head_entry,
  output tcaoq_pkg::fifo_stat_t stat
);

  tcaoq_pkg::entry_t                    store [tcaoq_pkg::QUEUE_DEPTH];
  logic [tcaoq_pkg::PTR_BITS-1:0]       head;
  logic [tcaoq_pkg::PTR_BITS-1:0]       head_next;
  logic [tcaoq_pkg::PTR_BITS-1:0]       tail;
  logic [tcaoq_pkg::CNT_BITS-1:0]       count;
  logic [tcaoq_pkg::CNT_BITS-1:0]       count_next;
  logic [tcaoq_pkg::CNT_BITS:0]         tail_sum;
  logic                                 do_push;
  logic                                 do_pop;

  // Occupancy flags.
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == tcaoq_pkg::CNT_BITS'(tcaoq_pkg::QUEUE_DEPTH));

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Write position is head plus occupancy, wrapped once.
  always_comb begin
    tail_sum = (tcaoq_pkg::CNT_BITS + 1)'(head) + (tcaoq_pkg::CNT_BITS + 1)'(count);
    if (tail_sum >= (tcaoq_pkg::CNT_BITS + 1)'(tcaoq_pkg::QUEUE_DEPTH)) begin
      tail = tcaoq_pkg::PTR_BITS'(tail_sum
             - (tcaoq_pkg::CNT_BITS + 1)'(tcaoq_pkg::QUEUE_DEPTH));
    end else begin
      tail = tcaoq_pkg::PTR_BITS'(tail_sum);
    end
  end

  // Pointer and count updates.
  always_comb begin
    head_next  = head;
    count_next = count;
    if (do_pop) begin
      if (head == tcaoq_pkg::PTR_BITS'(tcaoq_pkg::QUEUE_DEPTH - 1)) begin
        head_next = '0;
      end else begin
        head_next = head + tcaoq_pkg::PTR_BITS'(1);
      end
      count_next = count - tcaoq_pkg::CNT_BITS'(1);
    end else if (do_push) begin
      count_next = count + tcaoq_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Entry storage; contents need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[tail] <= push_entry;
    end
  end

  assign head_entry = store[head];

endmodule

### sv/tcaoq_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaoq_out_buf
// Two-slot result buffer: a result register plus a skid register, so a new
// request is taken while a finished result waits downstream.
// ----------------------------------------------------------------------------
module tcaoq_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcaoq_pkg::result_t push_result,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output tcaoq_pkg::result_t out_result
);

  tcaoq_pkg::result_t main_result;
  tcaoq_pkg::result_t skid_result;
  logic               main_valid;
  logic               skid_valid;
  logic               pop;

  assign pop        = main_valid && out_ready;
  assign can_push   = !skid_valid;
  assign out_valid  = main_valid;
  assign out_result = main_result;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_result <= skid_result;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_result <= push_result;
      end else begin
        main_result <= push_result;
      end
    end
  end

endmodule

### sv/two_class_age_ordered_queue.sv
`timescale 1ns / 1ps
// A result is registered into the result buffer when its request is accepted.
// One request per cycle while the result buffer has room; each request is decided
// combinationally from the two queue heads and a single stamp compare.
// A two-slot result buffer keeps requests flowing while one result waits.
// Reset clears both queue pointers and counts, the stamp counter and the
// result buffer; queue contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue
// Two bounded class queues sharing an arrival stamp counter, with per-class
// dequeue and an oldest-first dequeue across both classes.
// ----------------------------------------------------------------------------
module two_class_age_ordered_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tcaoq_pkg::DATA_BITS-1:0] s_tdata,   // tag
  input  logic [2:0]                      s_tuser,   // op[1:0], kind[2]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tcaoq_pkg::DATA_BITS-1:0] m_tdata,   // out_tag
  output logic [2:0]                      m_tuser    // status[1:0], out_kind[2]
);

  tcaoq_pkg::op_t        op;
  logic                  kind;
  tcaoq_pkg::tag_t       tag;
  logic                  accept;
  logic                  can_push;
  tcaoq_pkg::stamp_t     stamp;
  tcaoq_pkg::stamp_t     stamp_next;
  tcaoq_pkg::stamp_t     stamp_diff;
  tcaoq_pkg::entry_t     push_entry;
  tcaoq_pkg::entry_t     head0;
  tcaoq_pkg::entry_t     head1;
  tcaoq_pkg::fifo_stat_t stat0;
  tcaoq_pkg::fifo_stat_t stat1;
  tcaoq_pkg::result_t    result;
  tcaoq_pkg::result_t    out_result;
  logic                  push0;
  logic                  push1;
  logic                  take0;
  logic                  take1;
  logic                  first_older;

  // Request fields.
  assign op     = tcaoq_pkg::op_t'(s_tuser[1:0]);
  assign kind   = s_tuser[2];
  assign tag    = s_tdata[tcaoq_pkg::TAG_BITS-1:0];
  assign accept = s_tvalid && s_tready;
  assign s_tready = can_push;

  assign push_entry.tag   = tag;
  assign push_entry.stamp = stamp;

  // First-class head is older when the stamp distance is nonzero and below half.
  assign stamp_diff  = head1.stamp - head0.stamp;
  assign first_older = (stamp_diff != '0) && !stamp_diff[tcaoq_pkg::STAMP_BITS-1];

  // Request decode and result formation.
  always_comb begin
    push0         = 1'b0;
    push1         = 1'b0;
    take0         = 1'b0;
    take1         = 1'b0;
    stamp_next    = stamp;
    result.status = tcaoq_pkg::ST_OK;
    result.kind   = 1'b0;
    result.tag    = '0;
    unique case (op)
      tcaoq_pkg::OP_ENQ: begin
        if ((kind && stat1.full) || (!kind && stat0.full)) begin
          result.status = tcaoq_pkg::ST_FULL;
        end else begin
          push0      = !kind;
          push1      = kind;
          stamp_next = stamp + tcaoq_pkg::stamp_t'(1);
        end
      end
      tcaoq_pkg::OP_DEQ_ANY: begin
        if (!stat0.empty && !stat1.empty) begin
          take0 = first_older;
          take1 = !first_older;
        end else begin
          take0 = !stat0.empty;
          take1 = !stat1.empty;
        end
      end
      tcaoq_pkg::OP_DEQ_C0: begin
        take0 = !stat0.empty;
      end
      tcaoq_pkg::OP_DEQ_C1: begin
        take1 = !stat1.empty;
      end
      default: begin
        result.status = tcaoq_pkg::ST_EMPTY;
      end
    endcase
    if (take0) begin
      result.tag = head0.tag;
    end else if (take1) begin
      result.kind = 1'b1;
      result.tag  = head1.tag;
    end else if (op != tcaoq_pkg::OP_ENQ) begin
      result.status = tcaoq_pkg::ST_EMPTY;
    end
  end

  // Shared arrival stamp counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
    end else if (accept) begin
      stamp <= stamp_next;
    end
  end

  tcaoq_class_fifo u_fifo0 (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && push0),
    .push_entry (push_entry),
    .pop        (accept && take0),
    .head_entry (head0),
    .stat       (stat0)
  );

  tcaoq_class_fifo u_fifo1 (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && push1),
    .push_entry (push_entry),
    .pop        (accept && take1),
    .head_entry (head1),
    .stat       (stat1)
  );

  tcaoq_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_result (result),
    .can_push    (can_push),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  // Result packing.
  assign m_tdata = tcaoq_pkg::DATA_BITS'(out_result.tag);
  assign m_tuser = {out_result.kind, out_result.status};

`ifndef SYNTH
  // Occupancy never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (rst)
    (stat0.count <= tcaoq_pkg::CNT_BITS'(tcaoq_pkg::QUEUE_DEPTH)) &&
    (stat1.count <= tcaoq_pkg::CNT_BITS'(tcaoq_pkg::QUEUE_DEPTH)))
    else $error("class queue occupancy above depth");

  // A dropped enqueue must not advance the stamp counter.
  assert property (@(posedge clk) disable iff (rst)
    accept && (op == tcaoq_pkg::OP_ENQ) &&
    ((kind && stat1.full) || (!kind && stat0.full)) |=> $stable(stamp))
    else $error("stamp advanced on a full enqueue");

  // A dequeue-any with both queues occupied removes exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    accept && (op == tcaoq_pkg::OP_DEQ_ANY) && !stat0.empty && !stat1.empty |=>
    ((tcaoq_pkg::CNT_BITS + 1)'(stat0.count) + (tcaoq_pkg::CNT_BITS + 1)'(stat1.count)
     + (tcaoq_pkg::CNT_BITS + 1)'(1)) ==
    $past((tcaoq_pkg::CNT_BITS + 1)'(stat0.count) + (tcaoq_pkg::CNT_BITS + 1)'(stat1.count)))
    else $error("dequeue-any did not remove exactly one entry");
`endif

endmodule
